### hw/rtl/fsst_pkg.sv
// Shared types and codes for the frame-synced shadow table.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package fsst_pkg;

   // request modes
   localparam int MODE_BITS = 2;
   localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd3;

   // response kinds
   localparam int KIND_BITS = 2;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd2;

   // control register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAULT_INJECT_IF0 = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAULT_INJECT_IF1 = 1'd1;
   localparam int CSR_DATA_BITS = 1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } fsst_state_type;

endpackage

### hw/rtl/fsst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies; instanced for every table of the shadow table block.
`timescale 1ns / 1ps

module fsst_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/frame_synced_shadow_table.sv
// Frame-synced shadow table: setting and reference tables with busy marks.
// Depends on fsst_pkg and fsst_ram.
//
// channel  | direction | handshake            | contents
// ---------+-----------+----------------------+------------------------------------
// req      | in        | req_valid/req_stall  | mode, key, frame flags, new entry
// rsp      | out       | rsp_valid/rsp_stall  | kind, key echo, entry, fault report
// csr      | in        | csr_wr_en            | fault inject bits, one per interface
//
// Each item is taken in IDLE, reading the three tables synchronously, and ends
// in EXEC, which checks parity, writes back and loads the result register.
// After reset the busy marks of all 2 << CONN_BITS keys (1024 by default) are
// swept to zero with req_stall high; csr writes are taken throughout.
// A held result register stalls write back until rsp takes the beat.
`timescale 1ns / 1ps

module frame_synced_shadow_table #(
   parameter int CONN_BITS    = 9,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fsst_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [CONN_BITS-1:0]               req_connection,
   input  logic                               req_ifid,
   input  logic                               req_frame_head,
   input  logic                               req_frame_end,
   input  logic [PAYLOAD_BITS-1:0]            req_new_payload,
   input  logic                               req_new_enable,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fsst_pkg::KIND_BITS-1:0]     rsp_response_kind,
   output logic [CONN_BITS-1:0]               rsp_resp_connection,
   output logic                               rsp_resp_ifid,
   output logic                               rsp_was_delete,
   output logic                               rsp_success,
   output logic [PAYLOAD_BITS-1:0]            rsp_entry_payload,
   output logic                               rsp_entry_enable,
   output logic                               rsp_entry_parity,
   output logic                               rsp_fault_valid,
   output logic [CONN_BITS-1:0]               rsp_fault_connection,
   output logic                               rsp_fault_ifid,
   // control registers
   input  logic                               csr_wr_en,
   input  logic [fsst_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fsst_pkg::CSR_DATA_BITS-1:0] csr_wr_data
);

   localparam int KEY_BITS   = CONN_BITS + 1;
   localparam int NUM_KEYS   = 2 << CONN_BITS;
   localparam int ENTRY_BITS = PAYLOAD_BITS + 2;
   localparam int EN_POS     = PAYLOAD_BITS;
   localparam int PAR_POS    = PAYLOAD_BITS + 1;

   // sequencer
   fsst_pkg::fsst_state_type state_ff, state_in;
   logic [KEY_BITS-1:0] clear_cnt_ff, clear_cnt_in;
   logic clear_done;
   logic clear_we;
   logic req_fire;
   logic exec_fire;

   // captured request
   logic [fsst_pkg::MODE_BITS-1:0] mode_ff;
   logic [CONN_BITS-1:0]           conn_ff;
   logic                           ifid_ff;
   logic                           head_ff;
   logic                           eof_ff;
   logic [PAYLOAD_BITS-1:0]        npay_ff;
   logic                           nen_ff;

   // fault inject registers
   logic inj_if0_ff;
   logic inj_if1_ff;

   // memory ports
   logic [KEY_BITS-1:0]   req_key;
   logic [KEY_BITS-1:0]   exec_key;
   logic [ENTRY_BITS-1:0] set_rd;
   logic [ENTRY_BITS-1:0] ref_rd;
   logic                  busy_rd;
   logic                  set_we;
   logic                  ref_we;
   logic                  busy_we;
   logic [ENTRY_BITS-1:0] set_wd;
   logic [ENTRY_BITS-1:0] ref_wd;
   logic                  busy_wd;
   logic                  busy_ram_we;
   logic [KEY_BITS-1:0]   busy_ram_addr;
   logic                  busy_ram_wd;

   // result computation
   logic [ENTRY_BITS-1:0]          rep;
   logic [ENTRY_BITS-1:0]          st;
   logic                           inj;
   logic                           fault;
   logic                           was_del;
   logic                           succ;
   logic [fsst_pkg::KIND_BITS-1:0] kind;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [fsst_pkg::KIND_BITS-1:0] rsp_kind_ff;
   logic [CONN_BITS-1:0]           rsp_conn_ff;
   logic                           rsp_ifid_ff;
   logic                           rsp_was_del_ff;
   logic                           rsp_succ_ff;
   logic [ENTRY_BITS-1:0]          rsp_entry_ff;
   logic                           rsp_fault_ff;

   assign req_key  = {req_ifid, req_connection};
   assign exec_key = {ifid_ff, conn_ff};
   assign req_fire = req_valid && !req_stall;
   assign clear_done = &clear_cnt_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsst_pkg::ST_CLEAR: begin
            if (clear_done) state_in = fsst_pkg::ST_IDLE;
         end
         fsst_pkg::ST_IDLE: begin
            if (req_valid) state_in = fsst_pkg::ST_EXEC;
         end
         fsst_pkg::ST_EXEC: begin
            if (exec_fire) state_in = fsst_pkg::ST_IDLE;
         end
         default: state_in = fsst_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      exec_fire = 1'b0;
      clear_we  = 1'b0;
      case (state_ff)
         fsst_pkg::ST_CLEAR: begin
            clear_we = 1'b1;
         end
         fsst_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         fsst_pkg::ST_EXEC: begin
            exec_fire = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // clear sweep counter
   assign clear_cnt_in = clear_we ? clear_cnt_ff + 1'b1 : clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsst_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inj_if0_ff <= 1'b0;
         inj_if1_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fsst_pkg::CSR_FAULT_INJECT_IF0: inj_if0_ff <= csr_wr_data[0];
            fsst_pkg::CSR_FAULT_INJECT_IF1: inj_if1_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // capture the request beat
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_mode;
         conn_ff <= req_connection;
         ifid_ff <= req_ifid;
         head_ff <= req_frame_head;
         eof_ff  <= req_frame_end;
         npay_ff <= req_new_payload;
         nen_ff  <= req_new_enable;
      end
   end

   // read, modify and write back
   always_comb begin
      inj     = ifid_ff ? inj_if1_ff : inj_if0_ff;
      rep     = set_rd;
      st      = set_rd;
      kind    = fsst_pkg::KIND_LOOKUP;
      was_del = 1'b0;
      succ    = 1'b0;
      fault   = 1'b0;
      set_we  = 1'b0;
      ref_we  = 1'b0;
      busy_we = 1'b0;
      set_wd  = set_rd;
      ref_wd  = set_rd;
      busy_wd = 1'b0;
      case (mode_ff)
         fsst_pkg::MODE_LOOKUP: begin
            kind = fsst_pkg::KIND_LOOKUP;
            if (head_ff) begin
               rep     = set_rd;
               ref_we  = 1'b1;
               ref_wd  = set_rd;
               busy_we = 1'b1;
               busy_wd = 1'b1;
            end else begin
               rep     = ref_rd;
               busy_we = eof_ff;
               busy_wd = 1'b0;
            end
            fault = (^rep[EN_POS:0]) != rep[PAR_POS];
         end
         fsst_pkg::MODE_READ: begin
            kind  = fsst_pkg::KIND_READ;
            rep   = set_rd;
            fault = (^rep[EN_POS:0]) != rep[PAR_POS];
         end
         fsst_pkg::MODE_INSERT: begin
            kind    = fsst_pkg::KIND_UPDATE;
            succ    = 1'b1;
            st      = {(^npay_ff) ^ nen_ff ^ inj, nen_ff, npay_ff};
            rep     = st;
            set_we  = 1'b1;
            set_wd  = st;
            ref_we  = !busy_rd;
            ref_wd  = st;
         end
         fsst_pkg::MODE_DELETE: begin
            kind    = fsst_pkg::KIND_UPDATE;
            was_del = 1'b1;
            rep     = set_rd;
            succ    = set_rd[EN_POS];
            st      = {(^set_rd[PAYLOAD_BITS-1:0]) ^ inj, 1'b0, set_rd[PAYLOAD_BITS-1:0]};
            set_we  = 1'b1;
            set_wd  = st;
            ref_we  = !busy_rd;
            ref_wd  = st;
         end
         default: begin
            kind = fsst_pkg::KIND_LOOKUP;
         end
      endcase
   end

   // busy table port is shared with the clear sweep
   assign busy_ram_we   = clear_we || (exec_fire && busy_we);
   assign busy_ram_addr = clear_we ? clear_cnt_ff : exec_key;
   assign busy_ram_wd   = clear_we ? 1'b0 : busy_wd;

   fsst_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (NUM_KEYS)
   ) u_setting_ram (
      .clock   (clock),
      .wr_en   (exec_fire && set_we),
      .wr_addr (exec_key),
      .wr_data (set_wd),
      .rd_en   (req_fire),
      .rd_addr (req_key),
      .rd_data (set_rd)
   );

   fsst_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (NUM_KEYS)
   ) u_reference_ram (
      .clock   (clock),
      .wr_en   (exec_fire && ref_we),
      .wr_addr (exec_key),
      .wr_data (ref_wd),
      .rd_en   (req_fire),
      .rd_addr (req_key),
      .rd_data (ref_rd)
   );

   fsst_ram #(
      .WIDTH (1),
      .DEPTH (NUM_KEYS)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_ram_we),
      .wr_addr (busy_ram_addr),
      .wr_data (busy_ram_wd),
      .rd_en   (req_fire),
      .rd_addr (req_key),
      .rd_data (busy_rd)
   );

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_kind_ff    <= kind;
         rsp_conn_ff    <= conn_ff;
         rsp_ifid_ff    <= ifid_ff;
         rsp_was_del_ff <= was_del;
         rsp_succ_ff    <= succ;
         rsp_entry_ff   <= rep;
         rsp_fault_ff   <= fault;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_response_kind    = rsp_kind_ff;
   assign rsp_resp_connection  = rsp_conn_ff;
   assign rsp_resp_ifid        = rsp_ifid_ff;
   assign rsp_was_delete       = rsp_was_del_ff;
   assign rsp_success          = rsp_succ_ff;
   assign rsp_entry_payload    = rsp_entry_ff[PAYLOAD_BITS-1:0];
   assign rsp_entry_enable     = rsp_entry_ff[EN_POS];
   assign rsp_entry_parity     = rsp_entry_ff[PAR_POS];
   assign rsp_fault_valid      = rsp_fault_ff;
   assign rsp_fault_connection = rsp_fault_ff ? rsp_conn_ff : '0;
   assign rsp_fault_ifid       = rsp_fault_ff && rsp_ifid_ff;

endmodule

### hw/rtl/fsst_checker.sv
// Port-level checks for the frame-synced shadow table, bound to the top level.
// Depends on fsst_pkg and frame_synced_shadow_table.
`timescale 1ns / 1ps

module fsst_checker #(
   parameter int CONN_BITS    = 9,
   parameter int PAYLOAD_BITS = 32
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [fsst_pkg::KIND_BITS-1:0] rsp_response_kind,
   input logic                           rsp_was_delete,
   input logic [PAYLOAD_BITS-1:0]        rsp_entry_payload,
   input logic                           rsp_fault_valid,
   input logic [CONN_BITS-1:0]           rsp_fault_connection,
   input logic                           rsp_fault_ifid
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown after reset");

   // one item at a time: the beat after an accepted request is stalled
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one still in flight");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_entry_payload)))
      else $error("stalled result beat changed");

   // fault key is zero without a fault
   a_fault_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fault_valid) |->
         (rsp_fault_connection == '0 && !rsp_fault_ifid))
      else $error("fault key set without fault");

   // delete flag and faults only on their own kinds
   a_kind_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_was_delete || rsp_fault_valid)) |->
         ((rsp_was_delete && rsp_response_kind == fsst_pkg::KIND_UPDATE && !rsp_fault_valid)
          || (!rsp_was_delete && rsp_response_kind != fsst_pkg::KIND_UPDATE)))
      else $error("flag inconsistent with response kind");

endmodule

bind frame_synced_shadow_table fsst_checker #(
   .CONN_BITS    (CONN_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_fsst_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_response_kind    (rsp_response_kind),
   .rsp_was_delete       (rsp_was_delete),
   .rsp_entry_payload    (rsp_entry_payload),
   .rsp_fault_valid      (rsp_fault_valid),
   .rsp_fault_connection (rsp_fault_connection),
   .rsp_fault_ifid       (rsp_fault_ifid)
);

### tb/tb.sv
// Self-checking bench for frame_synced_shadow_table: a driver, a monitor and a table predictor.
// Depends on fsst_pkg and the frame_synced_shadow_table RTL; reads no files.
`timescale 1ns / 1ps

module tb;

   localparam int CONN_W     = 9;
   localparam int PAY_W      = 32;
   localparam int KEY_COUNT  = 2 << CONN_W;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic [fsst_pkg::MODE_BITS-1:0] mode;
      logic [CONN_W-1:0]              conn;
      logic                           ifid;
      logic                           frame_head;
      logic                           frame_end;
      logic [PAY_W-1:0]               new_payload;
      logic                           new_enable;
   } table_request_type;

   typedef struct packed {
      logic [fsst_pkg::KIND_BITS-1:0] kind;
      logic [CONN_W-1:0]              conn;
      logic                           ifid;
      logic                           was_delete;
      logic                           success;
      logic [PAY_W-1:0]               payload;
      logic                           enable;
      logic                           parity;
      logic                           fault;
      logic [CONN_W-1:0]              fault_conn;
      logic                           fault_ifid;
   } table_answer_type;

   typedef struct packed {
      logic [PAY_W-1:0] payload;
      logic             enable;
      logic             parity;
   } table_entry_type;

   typedef enum int {
      PACE_FULL,
      PACE_RANDOM,
      PACE_SPARSE
   } pace_type;

   localparam logic [fsst_pkg::MODE_BITS-1:0] ALL_MODES [4] =
      '{fsst_pkg::MODE_LOOKUP, fsst_pkg::MODE_READ, fsst_pkg::MODE_INSERT,
        fsst_pkg::MODE_DELETE};

   // fault inject setting per phase, bit i for phase i
   localparam bit [4:0] INJECT_IF0_PLAN = 5'b11010;
   localparam bit [4:0] INJECT_IF1_PLAN = 5'b01100;

   // dut ports
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [fsst_pkg::MODE_BITS-1:0]       req_mode = fsst_pkg::MODE_LOOKUP;
   logic [CONN_W-1:0]                    req_connection = '0;
   logic                                 req_ifid = 1'b0;
   logic                                 req_frame_head = 1'b0;
   logic                                 req_frame_end = 1'b0;
   logic [PAY_W-1:0]                     req_new_payload = '0;
   logic                                 req_new_enable = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [fsst_pkg::KIND_BITS-1:0]       rsp_response_kind;
   logic [CONN_W-1:0]                    rsp_resp_connection;
   logic                                 rsp_resp_ifid;
   logic                                 rsp_was_delete;
   logic                                 rsp_success;
   logic [PAY_W-1:0]                     rsp_entry_payload;
   logic                                 rsp_entry_enable;
   logic                                 rsp_entry_parity;
   logic                                 rsp_fault_valid;
   logic [CONN_W-1:0]                    rsp_fault_connection;
   logic                                 rsp_fault_ifid;
   logic                                 csr_wr_en = 1'b0;
   logic [fsst_pkg::CSR_INDEX_BITS-1:0]  csr_index = fsst_pkg::CSR_FAULT_INJECT_IF0;
   logic [fsst_pkg::CSR_DATA_BITS-1:0]   csr_wr_data = '0;

   // predictor state
   table_entry_type shadow_setting [KEY_COUNT];
   table_entry_type shadow_reference [KEY_COUNT];
   bit              shadow_busy [KEY_COUNT];
   bit              inject_mirror [2];

   // stimulus bookkeeping
   table_request_type pending_requests [$];
   table_answer_type  expected_answers [$];
   bit                key_written [KEY_COUNT];
   logic [9:0]        hot_keys [16];
   table_request_type beat_on_bus;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                send_wait = 0;
   int                send_left = 0;
   pace_type          send_pace = PACE_FULL;
   int                recv_wait = 0;
   int                recv_left = 0;
   pace_type          recv_pace = PACE_FULL;

   frame_synced_shadow_table i_dut (.*);

   always #5 clock = ~clock;

   // wait cycles ahead of one beat
   function automatic int pick_wait(input pace_type pace);
      case (pace)
         PACE_FULL:   return 0;
         PACE_RANDOM: return $urandom_range(0, 13);
         default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      endcase
   endfunction

   // table behavior: one request in, one answer out, state updated
   function automatic table_answer_type apply_table_request(input table_request_type r);
      table_answer_type a;
      table_entry_type  shown;
      table_entry_type  stored;
      logic [9:0]       key;
      a = '0;
      key = {r.ifid, r.conn};
      a.conn = r.conn;
      a.ifid = r.ifid;
      if (r.mode == fsst_pkg::MODE_LOOKUP || r.mode == fsst_pkg::MODE_READ) begin
         if (r.mode == fsst_pkg::MODE_READ) begin
            a.kind = fsst_pkg::KIND_READ;
            shown = shadow_setting[key];
         end else if (r.frame_head) begin
            // head wins over end: copy and mark busy
            a.kind = fsst_pkg::KIND_LOOKUP;
            shown = shadow_setting[key];
            shadow_reference[key] = shown;
            shadow_busy[key] = 1'b1;
         end else begin
            a.kind = fsst_pkg::KIND_LOOKUP;
            shown = shadow_reference[key];
            if (r.frame_end) shadow_busy[key] = 1'b0;
         end
         if ((^shown.payload ^ shown.enable) != shown.parity) begin
            a.fault = 1'b1;
            a.fault_conn = r.conn;
            a.fault_ifid = r.ifid;
         end
      end else begin
         a.kind = fsst_pkg::KIND_UPDATE;
         if (r.mode == fsst_pkg::MODE_INSERT) begin
            stored.payload = r.new_payload;
            stored.enable = r.new_enable;
            a.success = 1'b1;
         end else begin
            shown = shadow_setting[key];
            stored.payload = shown.payload;
            stored.enable = 1'b0;
            a.was_delete = 1'b1;
            a.success = shown.enable;
         end
         stored.parity = ^stored.payload ^ stored.enable ^ inject_mirror[r.ifid];
         if (r.mode == fsst_pkg::MODE_INSERT) shown = stored;
         shadow_setting[key] = stored;
         if (!shadow_busy[key]) shadow_reference[key] = stored;
      end
      a.payload = shown.payload;
      a.enable = shown.enable;
      a.parity = shown.parity;
      return a;
   endfunction

   task automatic report_error(input string msg);
      if (mismatch_count < 40) $display("ERROR @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // request driver: pops queued items, inserts random gaps between beats
   always @(posedge clock) begin : request_driver
      table_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) expected_answers.push_back(apply_table_request(beat_on_bus));
         if (send_wait > 0 || pending_requests.size() == 0) begin
            req_valid <= 1'b0;
            if (send_wait > 0) send_wait--;
         end else begin
            nxt = pending_requests.pop_front();
            beat_on_bus = nxt;
            req_mode <= nxt.mode;
            req_connection <= nxt.conn;
            req_ifid <= nxt.ifid;
            req_frame_head <= nxt.frame_head;
            req_frame_end <= nxt.frame_end;
            req_new_payload <= nxt.new_payload;
            req_new_enable <= nxt.new_enable;
            req_valid <= 1'b1;
            if (send_left == 0) begin
               send_pace = pace_type'($urandom_range(0, 2));
               send_left = $urandom_range(10, 60);
            end
            send_left--;
            send_wait = pick_wait(send_pace);
         end
      end
   end

   // response monitor: checks each beat against the oldest expected answer
   always @(posedge clock) begin : response_monitor
      table_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               report_error("response beat with no expected answer");
            end else begin
               want = expected_answers.pop_front();
               compare_field("response_kind", 32'(rsp_response_kind), 32'(want.kind));
               compare_field("resp_connection", 32'(rsp_resp_connection), 32'(want.conn));
               compare_field("resp_ifid", 32'(rsp_resp_ifid), 32'(want.ifid));
               compare_field("was_delete", 32'(rsp_was_delete), 32'(want.was_delete));
               compare_field("success", 32'(rsp_success), 32'(want.success));
               compare_field("entry_payload", rsp_entry_payload, want.payload);
               compare_field("entry_enable", 32'(rsp_entry_enable), 32'(want.enable));
               compare_field("entry_parity", 32'(rsp_entry_parity), 32'(want.parity));
               compare_field("fault_valid", 32'(rsp_fault_valid), 32'(want.fault));
               compare_field("fault_connection", 32'(rsp_fault_connection),
                             32'(want.fault_conn));
               compare_field("fault_ifid", 32'(rsp_fault_ifid), 32'(want.fault_ifid));
            end
            if (recv_left == 0) begin
               recv_pace = pace_type'($urandom_range(0, 2));
               recv_left = $urandom_range(10, 60);
            end
            recv_left--;
            recv_wait = pick_wait(recv_pace);
         end
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic bit coin();
      return bit'($urandom_range(0, 1));
   endfunction

   function automatic logic [PAY_W-1:0] random_payload();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return PAY_W'(1) << $urandom_range(0, PAY_W - 1);
         default: return PAY_W'($urandom());
      endcase
   endfunction

   function automatic logic [9:0] pick_key();
      if ($urandom_range(0, 4) != 0) return hot_keys[4'($urandom_range(0, 15))];
      return 10'($urandom_range(0, KEY_COUNT - 1));
   endfunction

   task automatic queue_request(input logic [fsst_pkg::MODE_BITS-1:0] mode,
                                input logic [9:0] key,
                                input bit head, input bit fend,
                                input logic [PAY_W-1:0] payload, input bit en);
      table_request_type r;
      r.mode = mode;
      r.ifid = key[9];
      r.conn = key[8:0];
      r.frame_head = head;
      r.frame_end = fend;
      r.new_payload = payload;
      r.new_enable = en;
      if (mode == fsst_pkg::MODE_INSERT) key_written[key] = 1'b1;
      pending_requests.push_back(r);
   endtask

   // well-formed frames, single ops and flag noise, mixed, mostly on a hot key set
   task automatic queue_random_items(input int count);
      int made;
      int inner;
      logic [9:0] key;
      made = 0;
      while (made < count) begin
         key = pick_key();
         if (!key_written[key]) begin
            // only written entries may be read
            queue_request(fsst_pkg::MODE_INSERT, key, coin(), coin(), random_payload(), coin());
            made++;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               queue_request(fsst_pkg::MODE_LOOKUP, key, 1'b1, $urandom_range(0, 7) == 0,
                             random_payload(), coin());
               inner = $urandom_range(0, 5);
               repeat (inner) begin
                  case ($urandom_range(0, 3))
                     0: queue_request(fsst_pkg::MODE_LOOKUP, key, 1'b0, 1'b0,
                                      random_payload(), coin());
                     1: queue_request(fsst_pkg::MODE_INSERT, key, coin(), coin(),
                                      random_payload(), coin());
                     2: queue_request(fsst_pkg::MODE_DELETE, key, coin(), coin(),
                                      random_payload(), coin());
                     default: queue_request(fsst_pkg::MODE_READ, key, coin(), coin(),
                                            random_payload(), coin());
                  endcase
               end
               queue_request(fsst_pkg::MODE_LOOKUP, key, 1'b0, 1'b1, random_payload(), coin());
               made += inner + 2;
            end
            5, 6, 7: begin
               queue_request(ALL_MODES[2'($urandom_range(0, 3))], key, coin(), coin(),
                             random_payload(), coin());
               made++;
            end
            default: begin
               queue_request(fsst_pkg::MODE_LOOKUP, key, coin(), coin(), random_payload(),
                             coin());
               made++;
            end
         endcase
      end
   endtask

   // block until nothing is queued, in flight or expected
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_answers.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // csr index equals the interface it controls
   task automatic write_fault_inject(input logic [fsst_pkg::CSR_INDEX_BITS-1:0] idx,
                                     input bit value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      inject_mirror[idx] = value;
   endtask

   initial begin : stimulus
      int phase;
      hot_keys[0] = {1'b0, 9'd0};
      hot_keys[1] = {1'b0, 9'd511};
      hot_keys[2] = {1'b1, 9'd0};
      hot_keys[3] = {1'b1, 9'd511};
      for (int i = 4; i < 16; i++) hot_keys[4'(i)] = 10'($urandom_range(0, KEY_COUNT - 1));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 5; phase++) begin
         if (phase > 0) wait_for_quiet();
         write_fault_inject(fsst_pkg::CSR_FAULT_INJECT_IF0, INJECT_IF0_PLAN[3'(phase)]);
         write_fault_inject(fsst_pkg::CSR_FAULT_INJECT_IF1, INJECT_IF1_PLAN[3'(phase)]);
         @(posedge clock);
         csr_wr_en <= 1'b0;
         @(negedge clock);

         if (phase == 0) begin
            // field extremes, then a full frame with updates held back while busy
            queue_request(fsst_pkg::MODE_INSERT, {1'b0, 9'd0}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_INSERT, {1'b1, 9'd511}, 1'b1, 1'b1, '1, 1'b1);
            queue_request(fsst_pkg::MODE_INSERT, {1'b0, 9'd511}, 1'b0, 1'b1, 32'h8000_0001,
                          1'b1);
            queue_request(fsst_pkg::MODE_INSERT, {1'b1, 9'd0}, 1'b1, 1'b0, 32'hA5A5_A5A5,
                          1'b0);
            queue_request(fsst_pkg::MODE_READ, {1'b0, 9'd0}, 1'b0, 1'b0, '1, 1'b1);
            queue_request(fsst_pkg::MODE_READ, {1'b1, 9'd511}, 1'b1, 1'b1, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd511}, 1'b1, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_INSERT, {1'b0, 9'd511}, 1'b0, 1'b0, 32'h1234_5678,
                          1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd511}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd511}, 1'b0, 1'b1, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd511}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_DELETE, {1'b0, 9'd511}, 1'b0, 1'b0, '1, 1'b1);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd511}, 1'b0, 1'b0, '0, 1'b0);
            // head and end together keep the key busy
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b1, 9'd511}, 1'b1, 1'b1, '0, 1'b0);
            queue_request(fsst_pkg::MODE_DELETE, {1'b1, 9'd511}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b1, 9'd511}, 1'b0, 1'b1, '0, 1'b0);
            queue_request(fsst_pkg::MODE_DELETE, {1'b1, 9'd511}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b1, 9'd0}, 1'b1, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b1, 9'd0}, 1'b0, 1'b1, '0, 1'b0);
            queue_random_items(110);
         end else if (phase == 3) begin
            // both interfaces inject: bad parity is reported on reads, never on updates
            queue_request(fsst_pkg::MODE_INSERT, {1'b0, 9'd5}, 1'b0, 1'b0, 32'h0000_00F1,
                          1'b1);
            queue_request(fsst_pkg::MODE_READ, {1'b0, 9'd5}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd5}, 1'b1, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_DELETE, {1'b0, 9'd5}, 1'b0, 1'b0, '0, 1'b0);
            queue_request(fsst_pkg::MODE_LOOKUP, {1'b0, 9'd5}, 1'b0, 1'b1, '0, 1'b0);
            queue_request(fsst_pkg::MODE_READ, {1'b0, 9'd5}, 1'b0, 1'b0, '0, 1'b0);
            queue_random_items(124);
         end else begin
            queue_random_items(130);
         end
      end

      wait_for_quiet();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
